// ----- hdl/afc_pkg.sv -----
// shared types and constants for the autoranging frequency counter
package afc_pkg;

    localparam int STAMP_W   = 32;
    localparam int FREQ_W    = 48;
    localparam int VAL_W     = 16;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int MULB_W    = 42;

    localparam logic [FREQ_W-1:0] FREQ_SAT = {FREQ_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STAMP_HZ    = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_WAITING = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LONG    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOSIG   = 3'd4;

    // input item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_EDGE = 1'b1;

    // work deferred to the multiply-divide unit
    typedef enum logic [1:0] {
        OP_NONE,
        OP_FREQ,
        OP_SHORT_PERIOD
    } afc_op_t;

    typedef enum logic {
        CS_IDLE,
        CS_WAIT
    } afc_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } afc_md_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic start_unit;
        logic finish;
    } afc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic out_free;
        logic unit_done;
    } afc_sts_t;

endpackage

// ----- hdl/afc_muldiv.sv -----
// sequential multiply then divide: floor(x*y/d), shift-add then restoring division
module afc_muldiv #(
    parameter int XW = 28
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [XW-1:0]                x,
    input  logic [afc_pkg::MULB_W-1:0]   y,
    input  logic [afc_pkg::STAMP_W-1:0]  d,
    output logic                         done,
    output logic [afc_pkg::FREQ_W-1:0]   q,
    output logic                         ovf
);
    import afc_pkg::*;

    localparam int PW = XW + MULB_W;
    localparam int CW = $clog2(PW + 1);

    afc_md_t             mode_reg, mode_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [PW-1:0]       acc_reg, acc_next;
    logic [XW-1:0]       xs_reg, xs_next;
    logic [MULB_W-1:0]   yb_reg, yb_next;
    logic [STAMP_W-1:0]  dv_reg, dv_next;
    logic [STAMP_W-1:0]  rem_reg, rem_next;
    logic [FREQ_W-1:0]   q_reg, q_next;
    logic                ovf_reg, ovf_next;
    logic                done_reg, done_next;
    logic [STAMP_W:0]    trial;
    logic                qbit;

    // one multiplier bit or one quotient bit per cycle
    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        xs_next   = xs_reg;
        yb_next   = yb_reg;
        dv_next   = dv_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        trial     = {rem_reg, acc_reg[PW-1]};
        qbit      = (trial >= {1'b0, dv_reg});
        case (mode_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    acc_next  = '0;
                    xs_next   = x;
                    yb_next   = y;
                    dv_next   = d;
                    cnt_next  = CW'(XW);
                    mode_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                acc_next = {acc_reg[PW-2:0], 1'b0}
                         + (xs_reg[XW-1] ? PW'(yb_reg) : PW'(0));
                xs_next  = {xs_reg[XW-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    cnt_next  = CW'(PW);
                    rem_next  = '0;
                    q_next    = '0;
                    ovf_next  = 1'b0;
                    mode_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                rem_next = qbit ? STAMP_W'(trial - {1'b0, dv_reg}) : trial[STAMP_W-1:0];
                acc_next = {acc_reg[PW-2:0], 1'b0};
                q_next   = {q_reg[FREQ_W-2:0], qbit};
                ovf_next = ovf_reg | q_reg[FREQ_W-1];
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_next = 1'b1;
                    mode_next = MD_IDLE;
                end
            end
            default:
            begin
                mode_next = MD_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MD_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        xs_reg  <= xs_next;
        yb_reg  <= yb_next;
        dv_reg  <= dv_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign ovf  = ovf_reg;

endmodule

// ----- hdl/afc_datapath.sv -----
// counter state, ranging logic, configuration and result register
module afc_datapath #(
    parameter int AVG_MAX      = 1024,
    parameter int TIMEOUT_INIT = 100
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  afc_pkg::afc_cmd_t              cmd,
    output afc_pkg::afc_sts_t              sts,
    input  logic                           cfg_write,
    input  logic [afc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           kind,
    input  logic [afc_pkg::STAMP_W-1:0]    stamp,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [afc_pkg::FREQ_W-1:0]     freq_millihertz,
    output logic [afc_pkg::STATUS_W-1:0]   status,
    output logic [afc_pkg::VAL_W-1:0]      period_now,
    output logic [afc_pkg::VAL_W-1:0]      timeout_now,
    output logic [$clog2(AVG_MAX+1)-1:0]   average_now
);
    import afc_pkg::*;

    localparam int AW = $clog2(AVG_MAX + 1);
    localparam int XW = VAL_W + 1 + AW;
    localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(1);

    // configuration
    logic [VAL_W-1:0]   pmin_reg, pmax_reg, tmin_reg, tmax_reg;
    logic [STAMP_W-1:0] hz_reg;
    logic [VAL_W-1:0]   pmin, pmax, tmin, tmax;

    // measurement state
    logic               phase_reg, phase_next;
    logic [VAL_W-1:0]   ec_reg, ec_next;
    logic [VAL_W-1:0]   period_reg, period_next;
    logic [VAL_W-1:0]   tl_reg, tl_next;
    logic [VAL_W-1:0]   el_reg, el_next;
    logic [AW-1:0]      avg_reg, avg_next;
    logic [AW-1:0]      wraps_reg, wraps_next;
    logic [STAMP_W-1:0] start_reg, start_next;
    logic [FREQ_W-1:0]  freq_reg, freq_next;
    afc_op_t            op_reg, op_next;
    logic [STATUS_W-1:0] pend_reg, pend_next;

    // result register
    logic               ov_reg, ov_next;
    logic [FREQ_W-1:0]  of_reg;
    logic [STATUS_W-1:0] os_reg;
    logic [VAL_W-1:0]   op_per_reg, ot_reg;
    logic [AW-1:0]      oa_reg;

    // step candidates
    logic               s_phase;
    logic [VAL_W-1:0]   s_ec, s_period, s_tl, s_el;
    logic [AW-1:0]      s_avg, s_wraps;
    logic [STAMP_W-1:0] s_start;
    logic [FREQ_W-1:0]  s_freq;
    afc_op_t            s_op;
    logic [STATUS_W-1:0] s_status;
    logic [XW-1:0]      s_x;
    logic [MULB_W-1:0]  s_y;
    logic [STAMP_W-1:0] s_d;

    logic [AW-1:0]      wraps1;
    logic [AW:0]        avg_dbl;
    logic [VAL_W-1:0]   el1, tl_half;
    logic [VAL_W+1:0]   tl_tri;
    logic [VAL_W+4:0]   el20, tl9;
    logic [STAMP_W-1:0] delta;

    // 0.95 of the edge count: times 19, then divide by 4 and by 5
    logic [VAL_W+4:0]   ec19;
    logic [VAL_W+2:0]   ec19q;
    logic [VAL_W+22:0]  ec_scaled;
    logic [VAL_W-1:0]   ec_long;

    // unit interface
    logic               u_done, u_ovf;
    logic [FREQ_W-1:0]  u_q;
    logic [VAL_W-1:0]   lp1, lp2, sp;
    logic [STATUS_W-1:0] ld_status;

    // zero limits act as one
    assign pmin = (pmin_reg == '0) ? VAL_ONE : pmin_reg;
    assign pmax = (pmax_reg == '0) ? VAL_ONE : pmax_reg;
    assign tmin = (tmin_reg == '0) ? VAL_ONE : tmin_reg;
    assign tmax = (tmax_reg == '0) ? VAL_ONE : tmax_reg;

    assign wraps1  = wraps_reg + AW'(1);
    assign avg_dbl = {avg_reg, 1'b0};
    assign el1     = (el_reg != {VAL_W{1'b1}}) ? el_reg + VAL_ONE : el_reg;
    assign tl_half = {1'b0, tl_reg[VAL_W-1:1]};
    assign tl_tri  = (VAL_W+2)'(tl_reg) * (VAL_W+2)'(3);
    assign el20    = (VAL_W+5)'(el_reg) * (VAL_W+5)'(20);
    assign tl9     = (VAL_W+5)'(tl_reg) * (VAL_W+5)'(9);
    assign delta   = stamp - start_reg;

    // divide by 5 as a multiply by ceil(2^22/5), exact for this range
    assign ec19      = (VAL_W+5)'(ec_reg) * (VAL_W+5)'(19);
    assign ec19q     = ec19[VAL_W+4:2];
    assign ec_scaled = (VAL_W+23)'(ec19q) * (VAL_W+23)'(838861);
    assign ec_long   = ec_scaled[VAL_W+21:22];

    // timeout period candidate, raised to pmin then lowered to pmax
    assign lp1 = (ec_long < pmin) ? pmin : ec_long;
    assign lp2 = (lp1 > pmax) ? pmax : lp1;

    // one input item: immediate updates and the deferred operation
    always_comb
    begin
        s_phase  = phase_reg;
        s_ec     = ec_reg;
        s_period = period_reg;
        s_tl     = tl_reg;
        s_el     = el_reg;
        s_avg    = avg_reg;
        s_wraps  = wraps_reg;
        s_start  = start_reg;
        s_freq   = freq_reg;
        s_op     = OP_NONE;
        s_status = ST_WAITING;
        s_x      = XW'(period_reg);
        s_y      = MULB_W'(tl_reg);
        s_d      = STAMP_W'(el_reg);
        if (kind == KIND_EDGE)
        begin
            if (ec_reg >= period_reg)
            begin
                s_ec = '0;
                if (!phase_reg)
                begin
                    s_start = stamp;
                    s_wraps = '0;
                    s_el    = '0;
                    s_phase = 1'b1;
                end
                else if (wraps1 >= avg_reg)
                begin
                    s_wraps = '0;
                    s_phase = 1'b0;
                    s_el    = '0;
                    if (el20 > tl9)
                    begin
                        s_status = ST_NEW;
                        if (delta == '0)
                        begin
                            s_freq = FREQ_SAT;
                        end
                        else
                        begin
                            s_op = OP_FREQ;
                            s_x  = XW'((VAL_W+1)'(period_reg) + (VAL_W+1)'(1)) * XW'(avg_reg);
                            s_y  = MULB_W'(hz_reg) * MULB_W'(1000);
                            s_d  = delta;
                        end
                    end
                    else
                    begin
                        s_status = ST_SHORT;
                        if (tl_reg > tmin)
                        begin
                            s_tl = (tl_half < tmin) ? tmin : tl_half;
                        end
                        else if (period_reg < pmax)
                        begin
                            if (el_reg == '0)
                            begin
                                s_period = pmax;
                            end
                            else
                            begin
                                s_op = OP_SHORT_PERIOD;
                            end
                        end
                        else
                        begin
                            s_avg = (avg_dbl > (AW+1)'(AVG_MAX)) ? AW'(AVG_MAX)
                                                                  : avg_dbl[AW-1:0];
                        end
                    end
                end
                else
                begin
                    s_wraps = wraps1;
                end
            end
            else
            begin
                s_ec = ec_reg + VAL_ONE;
            end
        end
        else
        begin
            s_el = el1;
            if (el1 >= tl_reg)
            begin
                s_phase  = 1'b0;
                s_el     = '0;
                s_status = ST_LONG;
                if (avg_reg > AW'(1))
                begin
                    s_avg = {1'b0, avg_reg[AW-1:1]};
                end
                else if (period_reg > pmin)
                begin
                    if (lp2 != period_reg)
                    begin
                        s_period = lp2;
                        s_ec     = '0;
                    end
                end
                else if (tl_reg < tmax)
                begin
                    s_tl = (tl_tri > (VAL_W+2)'(tmax)) ? tmax : tl_tri[VAL_W-1:0];
                end
                else
                begin
                    s_freq   = '0;
                    s_status = ST_NOSIG;
                end
            end
        end
    end

    // result of the deferred period update
    assign sp  = (u_ovf || (u_q > FREQ_W'(pmax))) ? pmax : u_q[VAL_W-1:0];

    // commit a step or the finished operation
    always_comb
    begin
        phase_next  = phase_reg;
        ec_next     = ec_reg;
        period_next = period_reg;
        tl_next     = tl_reg;
        el_next     = el_reg;
        avg_next    = avg_reg;
        wraps_next  = wraps_reg;
        start_next  = start_reg;
        freq_next   = freq_reg;
        op_next     = op_reg;
        pend_next   = pend_reg;
        ld_status   = pend_reg;
        if (cmd.take)
        begin
            phase_next  = s_phase;
            ec_next     = s_ec;
            period_next = s_period;
            tl_next     = s_tl;
            el_next     = s_el;
            avg_next    = s_avg;
            wraps_next  = s_wraps;
            start_next  = s_start;
            freq_next   = s_freq;
            op_next     = s_op;
            pend_next   = s_status;
            ld_status   = s_status;
        end
        else if (cmd.finish)
        begin
            op_next = OP_NONE;
            case (op_reg)
                OP_FREQ:
                begin
                    freq_next = u_ovf ? FREQ_SAT : u_q;
                end
                OP_SHORT_PERIOD:
                begin
                    period_next = sp;
                end
                default:
                begin
                    op_next = OP_NONE;
                end
            endcase
        end
    end

    // result register handshake
    always_comb
    begin
        ov_next = ov_reg;
        if (out_ready)
        begin
            ov_next = 1'b0;
        end
        if ((cmd.take && (s_op == OP_NONE)) || cmd.finish)
        begin
            ov_next = 1'b1;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmin_reg <= VAL_W'(16);
            pmax_reg <= VAL_W'(65535);
            tmin_reg <= VAL_W'(10);
            tmax_reg <= VAL_W'(10000);
            hz_reg   <= STAMP_W'(100000000);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PERIOD_MIN:  pmin_reg <= cfg_data[VAL_W-1:0];
                CFG_PERIOD_MAX:  pmax_reg <= cfg_data[VAL_W-1:0];
                CFG_TIMEOUT_MIN: tmin_reg <= cfg_data[VAL_W-1:0];
                CFG_TIMEOUT_MAX: tmax_reg <= cfg_data[VAL_W-1:0];
                CFG_STAMP_HZ:    hz_reg   <= cfg_data[STAMP_W-1:0];
                default:         hz_reg   <= hz_reg;
            endcase
        end
    end

    // measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 1'b0;
            ec_reg     <= '0;
            period_reg <= VAL_W'(65535);
            tl_reg     <= VAL_W'(TIMEOUT_INIT);
            el_reg     <= '0;
            avg_reg    <= AW'(1);
            wraps_reg  <= '0;
            start_reg  <= '0;
            freq_reg   <= '0;
            op_reg     <= OP_NONE;
            pend_reg   <= ST_WAITING;
            ov_reg     <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            ec_reg     <= ec_next;
            period_reg <= period_next;
            tl_reg     <= tl_next;
            el_reg     <= el_next;
            avg_reg    <= avg_next;
            wraps_reg  <= wraps_next;
            start_reg  <= start_next;
            freq_reg   <= freq_next;
            op_reg     <= op_next;
            pend_reg   <= pend_next;
            ov_reg     <= ov_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if ((cmd.take && (s_op == OP_NONE)) || cmd.finish)
        begin
            of_reg     <= freq_next;
            os_reg     <= ld_status;
            op_per_reg <= period_next;
            ot_reg     <= tl_next;
            oa_reg     <= avg_next;
        end
    end

    afc_muldiv #(
        .XW (XW)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_unit),
        .x     (s_x),
        .y     (s_y),
        .d     (s_d),
        .done  (u_done),
        .q     (u_q),
        .ovf   (u_ovf)
    );

    assign sts.need_div  = (s_op != OP_NONE);
    assign sts.out_free  = !ov_reg || out_ready;
    assign sts.unit_done = u_done;

    assign out_valid       = ov_reg;
    assign freq_millihertz = of_reg;
    assign status          = os_reg;
    assign period_now      = op_per_reg;
    assign timeout_now     = ot_reg;
    assign average_now     = oa_reg;

endmodule

// ----- hdl/afc_ctrl.sv -----
// controller: accepts items and waits on the multiply-divide unit
module afc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  afc_pkg::afc_sts_t  sts,
    output afc_pkg::afc_cmd_t  cmd
);
    import afc_pkg::*;

    afc_state_t state_reg, state_next;
    logic       take;

    assign take = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (take && sts.need_div)
                begin
                    state_next = CS_WAIT;
                end
            end
            CS_WAIT:
            begin
                if (sts.unit_done)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd.take       = 1'b0;
        cmd.start_unit = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready       = sts.out_free;
                cmd.take       = in_valid && sts.out_free;
                cmd.start_unit = in_valid && sts.out_free && sts.need_div;
            end
            CS_WAIT:
            begin
                cmd.finish = sts.unit_done;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/autoranging_frequency_counter_top.sv -----
// Autoranging reciprocal frequency counter. Each transfer on the input carries
// either a millisecond tick or a signal edge with its timestamp, and produces
// exactly one result transfer with the latest frequency in millihertz, a status
// code and the current period, timeout and averaging settings. Ticks and most
// edges finish without the multiply-divide unit, and a new item is taken as
// soon as the result register is free. An edge that ends a measurement with a
// valid interval, or a too-short interval that rescales the period, runs the
// shared bit-serial multiply-divide unit, one multiplier bit then one quotient
// bit per cycle; the next input is taken only once the controller is back in
// its idle state. Configuration is written through cfg_write, cfg_index and
// cfg_data; the user must write it only while the block is idle, and the block
// itself does not enforce this.
module autoranging_frequency_counter_top #(
    parameter int AVG_MAX      = 1024,
    parameter int TIMEOUT_INIT = 100
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [afc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic [afc_pkg::STAMP_W-1:0]    stamp,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [afc_pkg::FREQ_W-1:0]     freq_millihertz,
    output logic [afc_pkg::STATUS_W-1:0]   status,
    output logic [afc_pkg::VAL_W-1:0]      period_now,
    output logic [afc_pkg::VAL_W-1:0]      timeout_now,
    output logic [$clog2(AVG_MAX+1)-1:0]   average_now
);
    import afc_pkg::*;

    afc_cmd_t cmd;
    afc_sts_t sts;

    // control
    afc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    afc_datapath #(
        .AVG_MAX      (AVG_MAX),
        .TIMEOUT_INIT (TIMEOUT_INIT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .kind            (kind),
        .stamp           (stamp),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .freq_millihertz (freq_millihertz),
        .status          (status),
        .period_now      (period_now),
        .timeout_now     (timeout_now),
        .average_now     (average_now)
    );

endmodule

// ----- hdl/afc_checker.sv -----
// port-level checks for the frequency counter and their binding
module afc_checker #(
    parameter int AVG_MAX = 1024
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [afc_pkg::FREQ_W-1:0]     freq_millihertz,
    input logic [afc_pkg::STATUS_W-1:0]   status,
    input logic [$clog2(AVG_MAX+1)-1:0]   average_now
);
    import afc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(freq_millihertz)
                                    && $stable(status))
        else $error("stalled result changed");

    // no new item while a result is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // status code in range
    a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_NOSIG)
        else $error("status out of range");

    // averaging never drops to zero
    a_avg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> average_now != '0)
        else $error("average count zero");

    // no signal reports zero frequency
    a_nosig_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NOSIG |-> freq_millihertz == '0)
        else $error("no signal with nonzero frequency");

endmodule

bind autoranging_frequency_counter_top afc_checker #(.AVG_MAX(AVG_MAX)) u_afc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .freq_millihertz (freq_millihertz),
    .status          (status),
    .average_now     (average_now)
);
